>>> design/tmee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmee_pkg
// Shared widths, constants, types and digit split for the third-level mesh
// extent enumerator.
// ----------------------------------------------------------------------------
package tmee_pkg;

  localparam int LAT_W = 22;
  localparam int LON_W = 23;
  localparam int IDX_W = 13;
  localparam int DEC_W = 10;

  localparam logic [LAT_W-1:0] LAT_MAX = 22'd2399999;
  localparam logic [LON_W-1:0] LON_MIN = 23'd3600000;
  localparam logic [LON_W-1:0] LON_MAX = 23'd7199999;

  // lat / 300 = (lat >> 2) / 75, lon offset / 450 = (off >> 1) / 225
  localparam logic [19:0] LAT_RECIP = 20'd894785;
  localparam int          LAT_SHIFT = 26;
  localparam logic [21:0] LON_RECIP = 22'd2386093;
  localparam int          LON_SHIFT = 29;

  // idx / 10 by reciprocal
  localparam logic [IDX_W-1:0] DEC_RECIP = 13'd6554;
  localparam int               DEC_SHIFT = 16;
  localparam logic [IDX_W-1:0] TEN       = 13'd10;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [6:0] coarse;
    logic [2:0] middle;
    logic [3:0] fine;
  } digits_t;

  function automatic digits_t split_index(input idx_t idx);
    logic [2*IDX_W-1:0] prod;
    logic [DEC_W-1:0]   tens;
    idx_t               rem;
    digits_t            d;
    prod     = (2*IDX_W)'(idx) * (2*IDX_W)'(DEC_RECIP);
    tens     = prod[DEC_SHIFT +: DEC_W];
    rem      = idx - IDX_W'(tens) * TEN;
    d.coarse = tens[DEC_W-1:3];
    d.middle = tens[2:0];
    d.fine   = rem[3:0];
    return d;
  endfunction

endpackage

>>> design/tmee_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmee_req_if
// Request channel: command and latitude/longitude box.
// ----------------------------------------------------------------------------
interface tmee_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [tmee_pkg::LAT_W-1:0]  min_lat;
  logic [tmee_pkg::LON_W-1:0]  min_lon;
  logic [tmee_pkg::LAT_W-1:0]  max_lat;
  logic [tmee_pkg::LON_W-1:0]  max_lon;

  modport source (output valid, cmd, min_lat, min_lon, max_lat, max_lon, input ready);
  modport sink (input valid, cmd, min_lat, min_lon, max_lat, max_lon, output ready);
endinterface

>>> design/tmee_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmee_res_if
// Result channel: one mesh code or an empty result per request.
// ----------------------------------------------------------------------------
interface tmee_res_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic       last;
  logic [6:0] coarse_row;
  logic [6:0] coarse_col;
  logic [2:0] middle_row;
  logic [2:0] middle_col;
  logic [3:0] fine_row;
  logic [3:0] fine_col;

  modport source (output valid, valid_res, last, coarse_row, coarse_col, middle_row,
                  middle_col, fine_row, fine_col, input ready);
  modport sink (input valid, valid_res, last, coarse_row, coarse_col, middle_row,
                middle_col, fine_row, fine_col, output ready);
endinterface

>>> design/tmee_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmee_corner
// Saturates one box corner and converts it to row and column cell indexes.
// ----------------------------------------------------------------------------
module tmee_corner (
  input  logic [tmee_pkg::LAT_W-1:0] lat,
  input  logic [tmee_pkg::LON_W-1:0] lon,
  output tmee_pkg::idx_t             row,
  output tmee_pkg::idx_t             col
);

  logic [tmee_pkg::LAT_W-1:0] lat_sat;
  logic [tmee_pkg::LON_W-1:0] lon_sat;
  logic [tmee_pkg::LON_W-1:0] lon_off;
  logic [39:0]                lat_prod;
  logic [42:0]                lon_prod;

  always_comb begin
    if (lat > tmee_pkg::LAT_MAX) begin
      lat_sat = tmee_pkg::LAT_MAX;
    end else begin
      lat_sat = lat;
    end
    priority if (lon < tmee_pkg::LON_MIN) begin
      lon_sat = tmee_pkg::LON_MIN;
    end else if (lon > tmee_pkg::LON_MAX) begin
      lon_sat = tmee_pkg::LON_MAX;
    end else begin
      lon_sat = lon;
    end
    lon_off  = lon_sat - tmee_pkg::LON_MIN;
    lat_prod = 40'(lat_sat[21:2]) * 40'(tmee_pkg::LAT_RECIP);
    lon_prod = 43'(lon_off[21:1]) * 43'(tmee_pkg::LON_RECIP);
    row      = lat_prod[tmee_pkg::LAT_SHIFT +: tmee_pkg::IDX_W];
    col      = lon_prod[tmee_pkg::LON_SHIFT +: tmee_pkg::IDX_W];
  end

endmodule

>>> design/third_mesh_extent_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// third_mesh_extent_enumerator
// Loads a latitude/longitude box and walks its third-level mesh codes.
// ----------------------------------------------------------------------------
// One request per clock while the result side accepts results. The request
// passes an input register, a register after the corner-to-index
// multipliers, and the result register behind the row/column counters and
// digit split. A load request returns an empty result; each next request
// returns the next code of the box in row-major order, or an empty result
// when no walk is running (empty box, run done, or no load since reset).
module third_mesh_extent_enumerator (
  input  logic           clk,
  input  logic           rst,
  tmee_req_if.sink       req,
  tmee_res_if.source     res
);

  // input stage
  logic                       v0;
  logic                       cmd0;
  logic [tmee_pkg::LAT_W-1:0] min_lat0;
  logic [tmee_pkg::LON_W-1:0] min_lon0;
  logic [tmee_pkg::LAT_W-1:0] max_lat0;
  logic [tmee_pkg::LON_W-1:0] max_lon0;

  // index stage
  logic           v1;
  logic           cmd1;
  tmee_pkg::idx_t min_row1;
  tmee_pkg::idx_t min_col1;
  tmee_pkg::idx_t max_row1;
  tmee_pkg::idx_t max_col1;
  tmee_pkg::idx_t min_row_c;
  tmee_pkg::idx_t min_col_c;
  tmee_pkg::idx_t max_row_c;
  tmee_pkg::idx_t max_col_c;

  // enumeration state
  tmee_pkg::idx_t cur_row;
  tmee_pkg::idx_t cur_col;
  tmee_pkg::idx_t start_col;
  tmee_pkg::idx_t end_row;
  tmee_pkg::idx_t end_col;
  logic           running;

  logic             v2;
  logic             rdy0;
  logic             rdy1;
  logic             rdy2;
  logic             row_end;
  logic             col_end;
  tmee_pkg::digits_t row_dig;
  tmee_pkg::digits_t col_dig;

  assign rdy2      = !v2 || res.ready;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign req.ready = rdy0;
  assign res.valid = v2;

  tmee_corner u_min (
    .lat (min_lat0),
    .lon (min_lon0),
    .row (min_row_c),
    .col (min_col_c)
  );

  tmee_corner u_max (
    .lat (max_lat0),
    .lon (max_lon0),
    .row (max_row_c),
    .col (max_col_c)
  );

  assign row_end = (cur_row >= end_row);
  assign col_end = (cur_col >= end_col);
  assign row_dig = tmee_pkg::split_index(cur_row);
  assign col_dig = tmee_pkg::split_index(cur_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0      <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      running <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= req.valid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      // request transfer into input register
      if (req.valid && rdy0) begin
        cmd0     <= req.cmd;
        min_lat0 <= req.min_lat;
        min_lon0 <= req.min_lon;
        max_lat0 <= req.max_lat;
        max_lon0 <= req.max_lon;
      end
      if (v0 && rdy1) begin
        cmd1     <= cmd0;
        min_row1 <= min_row_c;
        min_col1 <= min_col_c;
        max_row1 <= max_row_c;
        max_col1 <= max_col_c;
      end
      if (v1 && rdy2) begin
        res.valid_res  <= 1'b0;
        res.last       <= 1'b0;
        res.coarse_row <= '0;
        res.coarse_col <= '0;
        res.middle_row <= '0;
        res.middle_col <= '0;
        res.fine_row   <= '0;
        res.fine_col   <= '0;
        if (cmd1 == tmee_pkg::CMD_LOAD) begin
          cur_row   <= min_row1;
          cur_col   <= min_col1;
          start_col <= min_col1;
          end_row   <= max_row1;
          end_col   <= max_col1;
          running   <= (max_row1 >= min_row1) && (max_col1 >= min_col1);
        end else if (running) begin
          res.valid_res  <= 1'b1;
          res.last       <= row_end && col_end;
          res.coarse_row <= row_dig.coarse;
          res.coarse_col <= col_dig.coarse;
          res.middle_row <= row_dig.middle;
          res.middle_col <= col_dig.middle;
          res.fine_row   <= row_dig.fine;
          res.fine_col   <= col_dig.fine;
          if (!col_end) begin
            cur_col <= cur_col + 1'b1;
          end else begin
            cur_col <= start_col;
            if (!row_end) begin
              cur_row <= cur_row + 1'b1;
            end else begin
              running <= 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends load and next requests to the third-level mesh extent enumerator with
// random gaps on both channels. Each returned code is checked against an
// in-bench model of the corner-to-cell conversion and the row-major walk.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int ROW_UNITS    = 300;
  localparam int COL_UNITS    = 450;
  localparam int FIRST_SPAN   = 80;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  localparam int unsigned LAT_TOP = 32'(tmee_pkg::LAT_MAX);
  localparam int unsigned LON_BOT = 32'(tmee_pkg::LON_MIN);
  localparam int unsigned LON_TOP = 32'(tmee_pkg::LON_MAX);

  typedef logic [tmee_pkg::LAT_W-1:0] lat_t;
  typedef logic [tmee_pkg::LON_W-1:0] lon_t;

  typedef struct packed {
    logic cmd;
    lat_t min_lat;
    lon_t min_lon;
    lat_t max_lat;
    lon_t max_lon;
  } box_req_t;

  typedef struct packed {
    logic       valid_res;
    logic       last;
    logic [6:0] coarse_row;
    logic [6:0] coarse_col;
    logic [2:0] middle_row;
    logic [2:0] middle_col;
    logic [3:0] fine_row;
    logic [3:0] fine_col;
  } mesh_code_t;

  logic clk;
  logic rst;

  tmee_req_if req ();
  tmee_res_if res ();

  third_mesh_extent_enumerator dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  box_req_t   pending_requests[$];
  mesh_code_t expected_codes[$];

  // walk state of the model
  logic [13:0] walk_row, walk_col, row_start_col, stop_row, stop_col;
  logic        walking;

  int send_wait, send_mode, recv_wait, recv_mode;
  int requests_sent, loads_sent, codes_seen, lasts_seen, empties_seen;
  int errors, results_seen, hold_left, cycle_count;
  logic hold_armed;

  task automatic enqueue_request(input box_req_t rq);
    pending_requests.insert(pending_requests.size(), rq);
  endtask

  task automatic enqueue_expected(input mesh_code_t code);
    expected_codes.insert(expected_codes.size(), code);
  endtask

  function automatic int row_of(input int unsigned lat);
    int unsigned l;
    l = (lat > LAT_TOP) ? LAT_TOP : lat;
    return int'(l / ROW_UNITS);
  endfunction

  function automatic int col_of(input int unsigned lon);
    int unsigned l;
    l = lon;
    if (l < LON_BOT) l = LON_BOT;
    if (l > LON_TOP) l = LON_TOP;
    return int'((l - LON_BOT) / COL_UNITS);
  endfunction

  function automatic mesh_code_t advance_mesh_walk(box_req_t rq);
    mesh_code_t code;
    int         r0, c0, r1, c1, r, c;
    logic       row_end, col_end;
    code = '0;
    if (rq.cmd == tmee_pkg::CMD_LOAD) begin
      r0 = row_of(32'(rq.min_lat));
      c0 = col_of(32'(rq.min_lon));
      r1 = row_of(32'(rq.max_lat));
      c1 = col_of(32'(rq.max_lon));
      walk_row      = 14'(r0);
      walk_col      = 14'(c0);
      row_start_col = 14'(c0);
      stop_row      = 14'(r1);
      stop_col      = 14'(c1);
      walking       = (r1 >= r0) && (c1 >= c0);
    end else if (walking) begin
      r = int'(walk_row);
      c = int'(walk_col);
      row_end = walk_row >= stop_row;
      col_end = walk_col >= stop_col;
      code.valid_res  = 1'b1;
      code.last       = row_end && col_end;
      code.coarse_row = 7'(r / FIRST_SPAN);
      code.coarse_col = 7'(c / FIRST_SPAN);
      code.middle_row = 3'((r / 10) % 8);
      code.middle_col = 3'((c / 10) % 8);
      code.fine_row   = 4'(r % 10);
      code.fine_col   = 4'(c % 10);
      if (!col_end) begin
        walk_col = walk_col + 14'd1;
      end else begin
        walk_col = row_start_col;
        if (!row_end) walk_row = walk_row + 14'd1;
        else walking = 1'b0;
      end
    end
    return code;
  endfunction

  function automatic int pick_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  task automatic add_load(input int unsigned lat0, input int unsigned lon0,
                          input int unsigned lat1, input int unsigned lon1);
    box_req_t rq;
    rq.cmd     = tmee_pkg::CMD_LOAD;
    rq.min_lat = lat_t'(lat0);
    rq.min_lon = lon_t'(lon0);
    rq.max_lat = lat_t'(lat1);
    rq.max_lon = lon_t'(lon1);
    enqueue_request(rq);
  endtask

  task automatic add_next(input int n);
    box_req_t rq;
    for (int i = 0; i < n; i++) begin
      rq.cmd     = tmee_pkg::CMD_NEXT;
      rq.min_lat = lat_t'($urandom);
      rq.min_lon = lon_t'($urandom);
      rq.max_lat = lat_t'($urandom);
      rq.max_lon = lon_t'($urandom);
      enqueue_request(rq);
    end
  endtask

  // small box, mostly walked to the end, sometimes cut short by a reload
  task automatic add_box_walk();
    int unsigned lat0, lat1;
    int unsigned lon0, lon1;
    int          cells;
    if ($urandom_range(0, 3) == 0) lat0 = $urandom_range(LAT_TOP - 1500, LAT_TOP + 600);
    else lat0 = $urandom_range(0, LAT_TOP);
    case ($urandom_range(0, 5))
      0:       lon0 = $urandom_range(LON_BOT - 900, LON_BOT + 1500);
      1:       lon0 = $urandom_range(LON_TOP - 2500, LON_TOP + 600);
      default: lon0 = $urandom_range(LON_BOT, LON_TOP);
    endcase
    lat1 = lat0 + $urandom_range(0, 4 * ROW_UNITS);
    lon1 = lon0 + $urandom_range(0, 5 * COL_UNITS);
    cells = (row_of(lat1) - row_of(lat0) + 1) * (col_of(lon1) - col_of(lon0) + 1);
    add_load(lat0, lon0, lat1, lon1);
    if ($urandom_range(0, 4) == 0) add_next($urandom_range(1, cells));
    else add_next(cells + $urandom_range(0, 2));
  endtask

  task automatic add_empty_box();
    int unsigned lat0, lat1;
    int unsigned lon0, lon1;
    if ($urandom_range(0, 1) == 0) begin
      lat0 = $urandom_range(3000, LAT_TOP);
      lat1 = lat0 - $urandom_range(ROW_UNITS, 2999);
      lon0 = $urandom_range(LON_BOT, LON_TOP - 3000);
      lon1 = lon0 + $urandom_range(0, 3000);
    end else begin
      lat0 = $urandom_range(0, LAT_TOP - 3000);
      lat1 = lat0 + $urandom_range(0, 3000);
      lon0 = $urandom_range(LON_BOT + 4500, LON_TOP);
      lon1 = lon0 - $urandom_range(COL_UNITS, 4499);
    end
    add_load(lat0, lon0, lat1, lon1);
    add_next($urandom_range(1, 2));
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    box_req_t rq;
    if (rst) begin
      req.valid     <= 1'b0;
      req.cmd       <= tmee_pkg::CMD_LOAD;
      req.min_lat   <= '0;
      req.min_lon   <= '0;
      req.max_lat   <= '0;
      req.max_lon   <= '0;
      walking       = 1'b0;
      walk_row      = '0;
      walk_col      = '0;
      row_start_col = '0;
      stop_row      = '0;
      stop_col      = '0;
      send_wait     = 0;
      send_mode     = 2;
    end else begin
      if (req.valid && req.ready) begin
        rq = {req.cmd, req.min_lat, req.min_lon, req.max_lat, req.max_lon};
        enqueue_expected(advance_mesh_walk(rq));
        requests_sent++;
        if (rq.cmd == tmee_pkg::CMD_LOAD) loads_sent++;
        if ($urandom_range(0, 63) == 0) send_mode = $urandom_range(0, 2);
      end
      if (!req.valid || req.ready) begin
        if (send_wait > 0 && hold_left == 0) begin
          send_wait--;
          req.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          rq = pending_requests.pop_front();
          req.cmd     <= rq.cmd;
          req.min_lat <= rq.min_lat;
          req.min_lon <= rq.min_lon;
          req.max_lat <= rq.max_lat;
          req.max_lon <= rq.max_lon;
          req.valid   <= 1'b1;
          send_wait = pick_wait(send_mode);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    mesh_code_t seen, want;
    if (rst) begin
      res.ready    <= 1'b0;
      results_seen <= 0;
      recv_wait = 0;
      recv_mode = 1;
    end else begin
      if (res.valid && res.ready) begin
        seen = {res.valid_res, res.last, res.coarse_row, res.coarse_col, res.middle_row,
                res.middle_col, res.fine_row, res.fine_col};
        results_seen <= results_seen + 1;
        if (expected_codes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result with nothing pending: %h", seen);
        end else begin
          want = expected_codes.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch at result %0d: expected v=%0d last=%0d row=%0d/%0d/%0d ",
                        "col=%0d/%0d/%0d, got v=%0d last=%0d row=%0d/%0d/%0d col=%0d/%0d/%0d"},
                       results_seen, want.valid_res, want.last, want.coarse_row,
                       want.middle_row, want.fine_row, want.coarse_col, want.middle_col,
                       want.fine_col, seen.valid_res, seen.last, seen.coarse_row,
                       seen.middle_row, seen.fine_row, seen.coarse_col, seen.middle_col,
                       seen.fine_col);
          end
          if (want.valid_res) codes_seen++;
          else empties_seen++;
          if (want.last) lasts_seen++;
        end
        if ($urandom_range(0, 63) == 0) recv_mode = $urandom_range(0, 2);
        recv_wait = pick_wait(recv_mode);
      end
      if (hold_left != 0) begin
        res.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // one long receiver hold-off so the pipeline backs up into the request side
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && results_seen >= HOLD_AFTER) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_codes.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int kind, directed;
    rst = 1'b1;

    // directed part
    add_next(1);
    add_load(0, LON_BOT, 0, LON_BOT);
    add_next(2);
    add_load('1, '1, '1, '1);
    add_next(2);
    add_load(299, 0, 300, LON_BOT + COL_UNITS);
    add_next(5);
    add_load(600, LON_BOT, 599, LON_TOP);
    add_next(1);
    add_load(0, LON_BOT + 900, LAT_TOP, LON_BOT + 899);
    add_next(1);
    add_load(1200, LON_BOT, 1800, LON_BOT);
    add_next(1);
    add_load(LAT_TOP, LON_TOP, LAT_TOP, LON_TOP);
    add_next(2);
    directed = pending_requests.size();

    // random part
    while (pending_requests.size() < directed + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        add_box_walk();
      end else if (kind == 7) begin
        add_load($urandom, $urandom, $urandom, $urandom);
        add_next($urandom_range(0, 4));
      end else if (kind == 8) begin
        add_empty_box();
      end else begin
        add_next($urandom_range(1, 3));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req.valid || expected_codes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d loads): %0d mesh codes, %0d closing a box, %0d empty results",
             requests_sent, loads_sent, codes_seen, lasts_seen, empties_seen);
    $display("one %0d-cycle result stall, %0d mismatches", HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
